/* hdl/assert_macros.svh */
//------------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with asynchronous reset.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante must imply cons in the same cycle
`define ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// expr must never hold
`define ASSERT_NEVER(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error(msg);

`endif

/* hdl/rpn_pkg.sv */
//------------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and sizes of the RPN stack evaluator.
//------------------------------------------------------------------------------
package rpn_pkg;

    localparam int DATA_W              = 32;
    localparam int OP_W                = 3;
    localparam int STATUS_W            = 3;
    localparam int COUNT_OUT_W         = 5;
    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FEW      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FINAL    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

    typedef enum logic [2:0] {
        K_PUSH,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_FINISH,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* hdl/rpn_front.sv */
//------------------------------------------------------------------------------
// rpn_front
// Input stage: accepts items, decodes the operation and hands commands to the
// queue.
//------------------------------------------------------------------------------
module rpn_front
    import rpn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] push_value,
    input  q_stat_t                  q_stat,
    output logic                     q_push,
    output cmd_t                     q_cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    cmd_t decoded;
    logic accept;

    always_comb
    begin
        case (operation)
            OP_PUSH:   decoded.kind = K_PUSH;
            OP_ADD:    decoded.kind = K_ADD;
            OP_SUB:    decoded.kind = K_SUB;
            OP_MUL:    decoded.kind = K_MUL;
            OP_DIV:    decoded.kind = K_DIV;
            OP_FINISH: decoded.kind = K_FINISH;
            default:   decoded.kind = K_NOP;
        endcase
        decoded.value = push_value;
    end

    assign in_stall = hold_valid_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = hold_valid_reg && !q_stat.full;
    assign q_cmd    = hold_cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = decoded;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

/* hdl/rpn_fifo.sv */
//------------------------------------------------------------------------------
// rpn_fifo
// Short command queue between the front and back parts.
//------------------------------------------------------------------------------
module rpn_fifo
    import rpn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    pop_cmd,
    output q_stat_t q_stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          q_mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          do_push;
    logic          do_pop;

    assign q_stat.full  = (fill_reg == FW'(QUEUE_DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_cmd      = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/rpn_div.sv */
//------------------------------------------------------------------------------
// rpn_div
// Signed divider, truncating toward zero; restoring, one quotient bit a cycle.
//------------------------------------------------------------------------------
module rpn_div
    import rpn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] quo_next;
    logic [DATA_W-1:0] mb_reg;
    logic [DATA_W-1:0] mb_next;
    logic              neg_reg;
    logic              neg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              na;
    logic              nb;

    assign na       = dividend[DATA_W-1];
    assign nb       = divisor[DATA_W-1];
    assign shifted  = {rem_reg, quo_reg[DATA_W-1]};
    assign diff     = shifted - {1'b0, mb_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            rem_next  = '0;
            quo_next  = na ? (~dividend + DATA_W'(1)) : dividend;
            mb_next   = nb ? (~divisor + DATA_W'(1)) : divisor;
            neg_next  = na != nb;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

endmodule

/* hdl/rpn_back.sv */
//------------------------------------------------------------------------------
// rpn_back
// Execution part: stack memory with a cached top entry, ALU sequencer and the
// result register.
//------------------------------------------------------------------------------
module rpn_back
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_avail,
    input  cmd_t                          cmd,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_W-1:0]      top_value,
    output logic [COUNT_OUT_W-1:0]        stack_count,
    output logic [STATUS_W-1:0]           status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV
    } state_t;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    state_t               state_reg;
    state_t               state_next;
    cmd_kind_t            kind_reg;
    cmd_kind_t            kind_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [DATA_W-1:0]    top_reg;
    logic [DATA_W-1:0]    top_next;
    logic [DATA_W-1:0]    prod_reg;
    logic [DATA_W-1:0]    prod_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DATA_W-1:0]    out_top_reg;
    logic [DATA_W-1:0]    out_top_next;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [COUNT_OUT_W-1:0] out_count_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [STATUS_W-1:0]  out_status_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic                 bin_done;
    logic [DATA_W-1:0]    bin_res;
    logic [STATUS_W-1:0]  bin_st;
    logic [CW-1:0]        count_dec;
    logic [DATA_W-1:0]    top_or_zero;
    logic                 div_start;
    logic                 div_done;
    logic [DATA_W-1:0]    div_quo;

    rpn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign count_dec   = count_reg - CW'(1);
    assign top_or_zero = (count_reg == '0) ? '0 : top_reg;
    assign out_valid   = out_valid_reg;
    assign top_value   = out_top_reg;
    assign stack_count = out_count_reg;
    assign status      = out_status_reg;
    assign mem_waddr   = AW'(count_dec);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_top_next    = out_top_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = AW'(count_reg - CW'(2));
        div_start       = 1'b0;
        bin_done        = 1'b0;
        bin_res         = '0;
        bin_st          = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_avail && !out_valid_reg)
                begin
                    cmd_pop   = 1'b1;
                    kind_next = cmd.kind;
                    case (cmd.kind)
                        K_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                out_top_next    = top_reg;
                                out_count_next  = COUNT_OUT_W'(count_reg);
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we          = count_reg != '0;
                                top_next        = cmd.value;
                                count_next      = count_reg + CW'(1);
                                out_top_next    = cmd.value;
                                out_count_next  = COUNT_OUT_W'(count_reg + CW'(1));
                                out_status_next = ST_OK;
                            end
                        end
                        K_ADD, K_SUB, K_MUL, K_DIV:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                out_valid_next  = 1'b1;
                                out_top_next    = top_or_zero;
                                out_count_next  = COUNT_OUT_W'(count_reg);
                                out_status_next = ST_FEW;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        K_FINISH:
                        begin
                            out_valid_next  = 1'b1;
                            out_top_next    = (count_reg == CW'(1)) ? top_reg : '0;
                            out_count_next  = '0;
                            out_status_next = (count_reg == CW'(1)) ? ST_FINAL : ST_INVALID;
                            count_next      = '0;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_top_next    = top_or_zero;
                            out_count_next  = COUNT_OUT_W'(count_reg);
                            out_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                case (kind_reg)
                    K_ADD:
                    begin
                        bin_done = 1'b1;
                        bin_res  = rd_data_reg + top_reg;
                    end
                    K_SUB:
                    begin
                        bin_done = 1'b1;
                        bin_res  = rd_data_reg - top_reg;
                    end
                    K_MUL:
                    begin
                        prod_next  = rd_data_reg * top_reg;
                        state_next = S_MUL;
                    end
                    K_DIV:
                    begin
                        if (top_reg == '0)
                        begin
                            bin_done = 1'b1;
                            bin_res  = '0;
                            bin_st   = ST_DIV_ZERO;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MUL:
            begin
                bin_done = 1'b1;
                bin_res  = prod_reg;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    bin_done = 1'b1;
                    bin_res  = div_quo;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // binary op retires: result becomes the cached top, a's slot is freed
        if (bin_done)
        begin
            state_next      = S_IDLE;
            top_next        = bin_res;
            count_next      = count_dec;
            out_valid_next  = 1'b1;
            out_top_next    = bin_res;
            out_count_next  = COUNT_OUT_W'(count_dec);
            out_status_next = bin_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_NOP;
            count_reg      <= '0;
            top_reg        <= '0;
            prod_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_top_reg    <= '0;
            out_count_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            prod_reg       <= prod_next;
            out_valid_reg  <= out_valid_next;
            out_top_reg    <= out_top_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= top_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

endmodule

/* hdl/rpn_stack_evaluator.sv */
// Reverse Polish integer evaluator. Items enter a one-entry input register and
// a four-entry command queue, so the input keeps taking items while the
// execution part works or a result waits. Push, finish, undefined codes and
// operators that find too few operands complete straight from the idle state;
// add and subtract do one stack memory read and then one ALU step, multiply
// adds a product register, divide by zero ends after the read, and divide waits
// for the bit-per-cycle restoring divider. A new command starts only once the
// previous result has left the output register. The top of stack is held in a
// register; the entries below it sit in a single-port memory of STACK_DEPTH
// words that needs no clearing.
//------------------------------------------------------------------------------
// rpn_stack_evaluator
// Top level: input stage, command queue and execution part.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] top_value,
    output logic [COUNT_OUT_W-1:0]   stack_count,
    output logic [STATUS_W-1:0]      status
);

    q_stat_t q_stat;
    logic    q_push;
    cmd_t    q_cmd;
    logic    q_pop;
    cmd_t    head_cmd;

    rpn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .push_value (push_value),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    rpn_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .pop_cmd  (head_cmd),
        .q_stat   (q_stat)
    );

    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (!q_stat.empty),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_value   (top_value),
        .stack_count (stack_count),
        .status      (status)
    );

    `ASSERT_NEVER(a_queue_full_empty, clk, rst_n, q_stat.full && q_stat.empty, "queue full and empty")
    `ASSERT_IMPL(a_final_clears, clk, rst_n, out_valid && (status == ST_FINAL), stack_count == '0, "finish left entries")
    `ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_valid && (status == ST_INVALID), (top_value == 0) && (stack_count == '0), "invalid result not cleared")
    `ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && (status == ST_FULL), stack_count == COUNT_OUT_W'(STACK_DEPTH), "full status with room left")

endmodule
